/* hw/rtl/sldrv_pkg.sv */
// Package for the status LED pattern driver.
// Holds the shared types, register indexes and pattern codes; no dependencies.
package sldrv_pkg;

    // Width of all tick counters and tick interval registers.
    localparam int CNT_W = 16;

    // Configuration port geometry: five 32-bit registers at 4-byte spacing.
    localparam int DATA_W = 32;
    localparam int ADDR_W = 5;
    localparam int IDX_W  = 3;

    // Register indexes on the configuration port.
    localparam logic [IDX_W-1:0] REG_COMBINED  = 3'd0;
    localparam logic [IDX_W-1:0] REG_SLOW      = 3'd1;
    localparam logic [IDX_W-1:0] REG_FAST      = 3'd2;
    localparam logic [IDX_W-1:0] REG_STEADY    = 3'd3;
    localparam logic [IDX_W-1:0] REG_TEST_STEP = 3'd4;

    // Reset values: 500 ms, 250 ms, 1000 ms and 250 ms at a 10 ms tick.
    localparam int TICK_MS   = 10;
    localparam int SLOW_MS   = 500;
    localparam int TEST_MS   = 250;
    localparam int STEADY_MS = 1000;
    localparam logic [CNT_W-1:0] SLOW_RST   = CNT_W'(SLOW_MS / TICK_MS);
    localparam logic [CNT_W-1:0] FAST_RST   = CNT_W'(TEST_MS / TICK_MS);
    localparam logic [CNT_W-1:0] STEADY_RST = CNT_W'(STEADY_MS / TICK_MS);
    localparam logic [CNT_W-1:0] TSTEP_RST  = CNT_W'(TEST_MS / TICK_MS);

    typedef enum logic [1:0] {
        MODE_TICK    = 2'd0,
        MODE_MODULE  = 2'd1,
        MODE_NETWORK = 2'd2,
        MODE_TEST    = 2'd3
    } mode_t;

    // LED pattern codes.
    localparam logic [2:0] PAT_OFF       = 3'd0;
    localparam logic [2:0] PAT_GREEN     = 3'd1;
    localparam logic [2:0] PAT_FLASH_G   = 3'd2;
    localparam logic [2:0] PAT_RED       = 3'd3;
    localparam logic [2:0] PAT_FLASH_R   = 3'd4;
    localparam logic [2:0] PAT_ALT_SLOW  = 3'd5;
    localparam logic [2:0] PAT_ALT_FAST  = 3'd6;

    // Lamp test step codes.
    localparam logic [3:0] TST_SEP_0   = 4'd0;
    localparam logic [3:0] TST_SEP_1   = 4'd1;
    localparam logic [3:0] TST_SEP_2   = 4'd2;
    localparam logic [3:0] TST_SEP_3   = 4'd3;
    localparam logic [3:0] TST_SEP_4   = 4'd4;
    localparam logic [3:0] TST_COMB_0  = 4'd5;
    localparam logic [3:0] TST_COMB_1  = 4'd6;
    localparam logic [3:0] TST_COMB_2  = 4'd7;
    localparam logic [3:0] TEST_ENDED  = 4'd8;

    typedef struct packed {
        logic             combined;
        logic [CNT_W-1:0] slow_ticks;
        logic [CNT_W-1:0] fast_ticks;
        logic [CNT_W-1:0] steady_ticks;
        logic [CNT_W-1:0] test_ticks;
    } cfg_t;

    typedef struct packed {
        logic module_green;
        logic module_red;
        logic network_green;
        logic network_red;
        logic test_running;
    } result_t;

    typedef struct packed {
        logic             g;
        logic             r;
        logic [CNT_W-1:0] reload;
    } step_t;

endpackage

/* hw/rtl/sldrv_cfg.sv */
// Configuration register file with an APB-style slave port.
// Depends on sldrv_pkg for register indexes, reset values and cfg_t.
module sldrv_cfg
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sldrv_pkg::ADDR_W-1:0] paddr,
    input  logic [sldrv_pkg::DATA_W-1:0] pwdata,
    output logic [sldrv_pkg::DATA_W-1:0] prdata,
    output sldrv_pkg::cfg_t             cfg
);

    logic                           combined_reg;
    logic [sldrv_pkg::CNT_W-1:0]    slow_reg;
    logic [sldrv_pkg::CNT_W-1:0]    fast_reg;
    logic [sldrv_pkg::CNT_W-1:0]    steady_reg;
    logic [sldrv_pkg::CNT_W-1:0]    tstep_reg;
    logic [sldrv_pkg::IDX_W-1:0]    idx;
    logic                           wr_en;

    assign idx   = paddr[sldrv_pkg::ADDR_W-1:2];
    assign wr_en = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            combined_reg <= 1'b0;
            slow_reg     <= sldrv_pkg::SLOW_RST;
            fast_reg     <= sldrv_pkg::FAST_RST;
            steady_reg   <= sldrv_pkg::STEADY_RST;
            tstep_reg    <= sldrv_pkg::TSTEP_RST;
        end
        else if (wr_en)
        begin
            case (idx)
                sldrv_pkg::REG_COMBINED:  combined_reg <= pwdata[0];
                sldrv_pkg::REG_SLOW:      slow_reg     <= pwdata[sldrv_pkg::CNT_W-1:0];
                sldrv_pkg::REG_FAST:      fast_reg     <= pwdata[sldrv_pkg::CNT_W-1:0];
                sldrv_pkg::REG_STEADY:    steady_reg   <= pwdata[sldrv_pkg::CNT_W-1:0];
                sldrv_pkg::REG_TEST_STEP: tstep_reg    <= pwdata[sldrv_pkg::CNT_W-1:0];
                default:                  ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            sldrv_pkg::REG_COMBINED:  prdata = {{(sldrv_pkg::DATA_W-1){1'b0}}, combined_reg};
            sldrv_pkg::REG_SLOW:
                prdata = {{(sldrv_pkg::DATA_W-sldrv_pkg::CNT_W){1'b0}}, slow_reg};
            sldrv_pkg::REG_FAST:
                prdata = {{(sldrv_pkg::DATA_W-sldrv_pkg::CNT_W){1'b0}}, fast_reg};
            sldrv_pkg::REG_STEADY:
                prdata = {{(sldrv_pkg::DATA_W-sldrv_pkg::CNT_W){1'b0}}, steady_reg};
            sldrv_pkg::REG_TEST_STEP:
                prdata = {{(sldrv_pkg::DATA_W-sldrv_pkg::CNT_W){1'b0}}, tstep_reg};
            default:                  prdata = '0;
        endcase
    end

    assign cfg.combined     = combined_reg;
    assign cfg.slow_ticks   = slow_reg;
    assign cfg.fast_ticks   = fast_reg;
    assign cfg.steady_ticks = steady_reg;
    assign cfg.test_ticks   = tstep_reg;

endmodule

/* hw/rtl/sldrv_engine.sv */
// Pattern state, countdowns, lamp test sequencer and LED levels.
// Depends on sldrv_pkg; updates once per fired transaction.
module sldrv_engine
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  sldrv_pkg::mode_t     mode,
    input  logic [2:0]           status,
    input  sldrv_pkg::cfg_t      cfg,
    output sldrv_pkg::result_t   res_next
);

    logic [2:0]                  mpat_reg, mpat_next;
    logic [2:0]                  npat_reg, npat_next;
    logic [2:0]                  cpat_reg, cpat_next;
    logic [sldrv_pkg::CNT_W-1:0] mcnt_reg, mcnt_next;
    logic [sldrv_pkg::CNT_W-1:0] ncnt_reg, ncnt_next;
    logic [3:0]                  tstep_reg, tstep_next;
    logic [sldrv_pkg::CNT_W-1:0] tcnt_reg, tcnt_next;
    logic [3:0]                  lv_reg, lv_next;

    logic [2:0]                  ev_pat;
    logic [2:0]                  mod_run_pat;
    sldrv_pkg::step_t            mstep;
    sldrv_pkg::step_t            nstep;
    logic                        comb;

    // A zero interval register behaves as one tick.
    function automatic logic [sldrv_pkg::CNT_W-1:0] interval(
        input logic [sldrv_pkg::CNT_W-1:0] v);
        interval = (v == '0) ? sldrv_pkg::CNT_W'(1) : v;
    endfunction

    function automatic sldrv_pkg::step_t pattern_step(
        input logic g, input logic r, input logic [2:0] pat, input sldrv_pkg::cfg_t c);
        sldrv_pkg::step_t s;
        s.g = 1'b1;
        s.r = 1'b1;
        s.reload = interval(c.steady_ticks);
        case (pat)
            sldrv_pkg::PAT_OFF:
            begin
                s.g = 1'b0;
                s.r = 1'b0;
            end
            sldrv_pkg::PAT_GREEN:
            begin
                s.g = 1'b1;
                s.r = 1'b0;
            end
            sldrv_pkg::PAT_FLASH_G:
            begin
                s.g = !g;
                s.r = 1'b0;
                s.reload = interval(c.slow_ticks);
            end
            sldrv_pkg::PAT_RED:
            begin
                s.g = 1'b0;
                s.r = 1'b1;
            end
            sldrv_pkg::PAT_FLASH_R:
            begin
                s.g = 1'b0;
                s.r = !r;
                s.reload = interval(c.slow_ticks);
            end
            sldrv_pkg::PAT_ALT_SLOW, sldrv_pkg::PAT_ALT_FAST:
            begin
                s.g = !g;
                s.r = g;
                s.reload = (pat == sldrv_pkg::PAT_ALT_SLOW) ? interval(c.slow_ticks)
                                                              : interval(c.fast_ticks);
            end
            default:
            begin
                s.g = 1'b1;
                s.r = 1'b1;
            end
        endcase
        return s;
    endfunction

    assign comb        = cfg.combined;
    assign mod_run_pat = comb ? cpat_reg : mpat_reg;
    assign mstep       = pattern_step(lv_reg[0], lv_reg[1], mod_run_pat, cfg);
    assign nstep       = pattern_step(lv_reg[2], lv_reg[3], npat_reg, cfg);

    // Status code to pattern translation for the event in hand.
    always_comb
    begin
        ev_pat = sldrv_pkg::PAT_OFF;
        if (mode == sldrv_pkg::MODE_MODULE)
        begin
            case (status)
                3'd0:    ev_pat = sldrv_pkg::PAT_GREEN;
                3'd1:    ev_pat = sldrv_pkg::PAT_FLASH_G;
                3'd2:    ev_pat = sldrv_pkg::PAT_FLASH_R;
                3'd3:    ev_pat = sldrv_pkg::PAT_RED;
                3'd4:    ev_pat = sldrv_pkg::PAT_ALT_SLOW;
                default: ev_pat = sldrv_pkg::PAT_OFF;
            endcase
        end
        else
        begin
            case (status)
                3'd0:    ev_pat = sldrv_pkg::PAT_OFF;
                3'd1:    ev_pat = sldrv_pkg::PAT_FLASH_G;
                3'd2:    ev_pat = sldrv_pkg::PAT_GREEN;
                3'd3:    ev_pat = sldrv_pkg::PAT_FLASH_R;
                3'd4:    ev_pat = sldrv_pkg::PAT_RED;
                3'd5:    ev_pat = sldrv_pkg::PAT_ALT_FAST;
                default: ev_pat = sldrv_pkg::PAT_OFF;
            endcase
        end
    end

    always_comb
    begin
        mpat_next  = mpat_reg;
        npat_next  = npat_reg;
        cpat_next  = cpat_reg;
        mcnt_next  = mcnt_reg;
        ncnt_next  = ncnt_reg;
        tstep_next = tstep_reg;
        tcnt_next  = tcnt_reg;
        lv_next    = lv_reg;

        if (fire)
        begin
            case (mode)
                sldrv_pkg::MODE_TICK:
                begin
                    if (tstep_reg != sldrv_pkg::TEST_ENDED)
                    begin
                        if (tcnt_reg <= sldrv_pkg::CNT_W'(1))
                        begin
                            tcnt_next = interval(cfg.test_ticks);
                            // One lamp test step; network writes fold onto
                            // the module pair when combined.
                            case (tstep_reg)
                                sldrv_pkg::TST_SEP_0:
                                begin
                                    if (comb)
                                        lv_next[1:0] = 2'b00;
                                    else
                                        lv_next = 4'b0001;
                                    tstep_next = sldrv_pkg::TST_SEP_1;
                                end
                                sldrv_pkg::TST_SEP_1:
                                begin
                                    lv_next[1:0] = 2'b10;
                                    tstep_next = sldrv_pkg::TST_SEP_2;
                                end
                                sldrv_pkg::TST_SEP_2:
                                begin
                                    lv_next[1:0] = 2'b01;
                                    if (!comb)
                                        lv_next[2] = 1'b1;
                                    tstep_next = sldrv_pkg::TST_SEP_3;
                                end
                                sldrv_pkg::TST_SEP_3:
                                begin
                                    if (comb)
                                        lv_next[1:0] = 2'b10;
                                    else
                                        lv_next[3:2] = 2'b10;
                                    tstep_next = sldrv_pkg::TST_SEP_4;
                                end
                                sldrv_pkg::TST_SEP_4:
                                begin
                                    if (comb)
                                        lv_next[1] = 1'b0;
                                    else
                                        lv_next[3] = 1'b0;
                                    tstep_next = sldrv_pkg::TEST_ENDED;
                                end
                                sldrv_pkg::TST_COMB_0:
                                begin
                                    lv_next[1:0] = 2'b01;
                                    tstep_next = sldrv_pkg::TST_COMB_1;
                                end
                                sldrv_pkg::TST_COMB_1:
                                begin
                                    lv_next[1:0] = 2'b10;
                                    tstep_next = sldrv_pkg::TST_COMB_2;
                                end
                                sldrv_pkg::TST_COMB_2:
                                begin
                                    lv_next[1:0] = 2'b00;
                                    tstep_next = sldrv_pkg::TEST_ENDED;
                                end
                                default:
                                begin
                                    tstep_next = sldrv_pkg::TEST_ENDED;
                                end
                            endcase
                            if (tstep_next == sldrv_pkg::TEST_ENDED)
                            begin
                                mcnt_next = '0;
                                ncnt_next = '0;
                            end
                        end
                        else
                        begin
                            tcnt_next = tcnt_reg - sldrv_pkg::CNT_W'(1);
                        end
                    end
                    else
                    begin
                        if (mcnt_reg == '0)
                        begin
                            lv_next[1:0] = {mstep.r, mstep.g};
                            mcnt_next    = mstep.reload - sldrv_pkg::CNT_W'(1);
                        end
                        else
                        begin
                            mcnt_next = mcnt_reg - sldrv_pkg::CNT_W'(1);
                        end
                        if (!comb)
                        begin
                            if (ncnt_reg == '0)
                            begin
                                lv_next[3:2] = {nstep.r, nstep.g};
                                ncnt_next    = nstep.reload - sldrv_pkg::CNT_W'(1);
                            end
                            else
                            begin
                                ncnt_next = ncnt_reg - sldrv_pkg::CNT_W'(1);
                            end
                        end
                    end
                end
                sldrv_pkg::MODE_MODULE:
                begin
                    if (status < 3'd5 && mpat_reg != ev_pat)
                    begin
                        mpat_next = ev_pat;
                        if (ev_pat == sldrv_pkg::PAT_FLASH_R)
                            cpat_next = sldrv_pkg::PAT_FLASH_R;
                        mcnt_next = '0;
                    end
                end
                sldrv_pkg::MODE_NETWORK:
                begin
                    if (status < 3'd6 && npat_reg != ev_pat)
                    begin
                        npat_next = ev_pat;
                        cpat_next = ev_pat;
                        ncnt_next = '0;
                    end
                end
                sldrv_pkg::MODE_TEST:
                begin
                    if (tstep_reg == sldrv_pkg::TEST_ENDED)
                    begin
                        tstep_next = comb ? sldrv_pkg::TST_COMB_0 : sldrv_pkg::TST_SEP_0;
                        tcnt_next  = interval(cfg.test_ticks);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mpat_reg  <= sldrv_pkg::PAT_GREEN;
            npat_reg  <= sldrv_pkg::PAT_GREEN;
            cpat_reg  <= sldrv_pkg::PAT_GREEN;
            mcnt_reg  <= '0;
            ncnt_reg  <= '0;
            tstep_reg <= sldrv_pkg::TEST_ENDED;
            tcnt_reg  <= '0;
            lv_reg    <= '0;
        end
        else
        begin
            mpat_reg  <= mpat_next;
            npat_reg  <= npat_next;
            cpat_reg  <= cpat_next;
            mcnt_reg  <= mcnt_next;
            ncnt_reg  <= ncnt_next;
            tstep_reg <= tstep_next;
            tcnt_reg  <= tcnt_next;
            lv_reg    <= lv_next;
        end
    end

    // Result fields as they will read after this transaction.
    assign res_next.module_green  = lv_next[0];
    assign res_next.module_red    = lv_next[1];
    assign res_next.network_green = comb ? lv_next[0] : lv_next[2];
    assign res_next.network_red   = comb ? lv_next[1] : lv_next[3];
    assign res_next.test_running  = (tstep_next != sldrv_pkg::TEST_ENDED);

endmodule

/* hw/rtl/status_led_pattern_driver.sv */
// Status LED pattern driver top level: input register, pattern engine, result register.
// A transaction passes the input register, then the result register once it has room.
// Throughput: one transaction per cycle unless stalled, set by the single-pass update.
// Reset (rst_n low, asynchronous) clears both pipeline stages, sets all patterns
// to steady green, LEDs off, no lamp test, and loads the default tick intervals.
// Depends on sldrv_pkg, sldrv_cfg and sldrv_engine.
module status_led_pattern_driver
(
    input  logic                         clk,
    input  logic                         rst_n,
    // Configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sldrv_pkg::ADDR_W-1:0] paddr,
    input  logic [sldrv_pkg::DATA_W-1:0] pwdata,
    output logic [sldrv_pkg::DATA_W-1:0] prdata,
    output logic                         pready,
    // Input channel
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   mode,
    input  logic [2:0]                   status,
    // Result channel
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         module_green,
    output logic                         module_red,
    output logic                         network_green,
    output logic                         network_red,
    output logic                         test_running
);

    sldrv_pkg::cfg_t     cfg;
    sldrv_pkg::result_t  res_next;
    sldrv_pkg::result_t  res_reg;

    // Input register stage.
    logic                s1_valid_reg, s1_valid_next;
    sldrv_pkg::mode_t    s1_mode_reg;
    logic [2:0]          s1_status_reg;

    // Result register stage.
    logic                out_valid_reg, out_valid_next;

    logic                accept;
    logic                advance;

    assign pready = 1'b1;

    sldrv_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // The held transaction moves into the result register whenever that
    // register is empty or its content is being taken this cycle. The input
    // stage therefore stalls only when it is full and the result side is
    // stalled, so one new transaction is still taken while a result waits.
    assign advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_mode_reg   <= sldrv_pkg::mode_t'(mode);
            s1_status_reg <= status;
        end
        if (advance)
            res_reg <= res_next;
    end

    // The engine updates all pattern state on the advancing transaction and
    // presents the LED levels that follow from it.
    sldrv_engine u_engine
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (advance),
        .mode     (s1_mode_reg),
        .status   (s1_status_reg),
        .cfg      (cfg),
        .res_next (res_next)
    );

    assign out_valid     = out_valid_reg;
    assign module_green  = res_reg.module_green;
    assign module_red    = res_reg.module_red;
    assign network_green = res_reg.network_green;
    assign network_red   = res_reg.network_red;
    assign test_running  = res_reg.test_running;

    // The input side only stalls when both stages are full and the result
    // side is stalled.
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled while the pipeline had room");

    // A held transaction is never dropped while the result side is blocked.
    a_hold_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && out_stall) |=> s1_valid_reg)
        else $error("held transaction lost while result stalled");

    // A lamp test request always yields a result that shows the test running.
    a_test_start_shows: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s1_mode_reg == sldrv_pkg::MODE_TEST) |=> (out_valid && test_running))
        else $error("lamp test request did not show a running test");

endmodule

/* dv/status_led_pattern_driver_test.sv */
// Self-checking testbench for the status LED pattern driver.
// It holds its own LED pattern predictor in a small scoreboard class and checks every result.
// It depends on sldrv_pkg and the status_led_pattern_driver RTL.
module status_led_pattern_driver_test;

    import sldrv_pkg::*;

    // The run is cut off here, at many times what a correct run takes.
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_ITEMS  = 150;
    localparam int PHASE_COUNT  = 6;
    // A margin after each drain that covers the input and result registers.
    localparam int DRAIN_MARGIN = 6;
    localparam int PRINT_CAP    = 200;

    // These are the bit positions of the four LED levels in the predictor's level word.
    localparam logic [3:0] LV_MG = 4'b0001;
    localparam logic [3:0] LV_MR = 4'b0010;
    localparam logic [3:0] LV_NG = 4'b0100;
    localparam logic [3:0] LV_NR = 4'b1000;

    // Module status codes.
    localparam logic [2:0] MST_OPERATIONAL = 3'd0;
    localparam logic [2:0] MST_STANDBY     = 3'd1;
    localparam logic [2:0] MST_MINOR       = 3'd2;
    localparam logic [2:0] MST_UNRECOV     = 3'd3;
    localparam logic [2:0] MST_SELF_TEST   = 3'd4;

    // Network status codes.
    localparam logic [2:0] NST_OFFLINE   = 3'd0;
    localparam logic [2:0] NST_ONLINE    = 3'd1;
    localparam logic [2:0] NST_CONNECTED = 3'd2;
    localparam logic [2:0] NST_TIMEOUT   = 3'd3;
    localparam logic [2:0] NST_LINK_FAIL = 3'd4;
    localparam logic [2:0] NST_IDENTIFY  = 3'd5;

    // The scoreboard keeps a full copy of the driver state. Each accepted transaction
    // advances that copy and queues the LED levels the block must then show.
    class led_scoreboard;
        logic             combined;
        logic [CNT_W-1:0] slow_ticks;
        logic [CNT_W-1:0] fast_ticks;
        logic [CNT_W-1:0] steady_ticks;
        logic [CNT_W-1:0] lamp_ticks;
        logic [2:0]       mod_pat;
        logic [2:0]       net_pat;
        logic [2:0]       comb_pat;
        logic [CNT_W-1:0] mod_cnt;
        logic [CNT_W-1:0] net_cnt;
        logic [CNT_W-1:0] lamp_cnt;
        logic [3:0]       lamp_step;
        logic [3:0]       levels;
        result_t          leds_due[$];
        int               errors;

        function new();
            errors = 0;
            combined = 1'b0;
            slow_ticks = 16'd50;
            fast_ticks = 16'd25;
            steady_ticks = 16'd100;
            lamp_ticks = 16'd25;
            mod_pat = PAT_GREEN;
            net_pat = PAT_GREEN;
            comb_pat = PAT_GREEN;
            mod_cnt = '0;
            net_cnt = '0;
            lamp_cnt = '0;
            lamp_step = TEST_ENDED;
            levels = '0;
        endfunction

        task report(string what);
            if (errors < PRINT_CAP)
                $display("%0t mismatch: %s", $time, what);
            errors++;
        endtask

        function int pending();
            return leds_due.size();
        endfunction

        function void write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] value);
            case (idx)
                REG_COMBINED:  combined = value[0];
                REG_SLOW:      slow_ticks = value[CNT_W-1:0];
                REG_FAST:      fast_ticks = value[CNT_W-1:0];
                REG_STEADY:    steady_ticks = value[CNT_W-1:0];
                REG_TEST_STEP: lamp_ticks = value[CNT_W-1:0];
                default: ;
            endcase
        endfunction

        // A zero interval behaves as one tick.
        function logic [CNT_W-1:0] ticks_or_one(logic [CNT_W-1:0] ticks);
            return (ticks == '0) ? CNT_W'(1) : ticks;
        endfunction

        // In combined mode a write aimed at the network pair lands on the module pair.
        function void set_pair(logic [3:0] g_bit, logic [3:0] r_bit, logic g, logic r);
            if (combined && g_bit == LV_NG)
            begin
                g_bit = LV_MG;
                r_bit = LV_MR;
            end
            levels = levels & ~(g_bit | r_bit);
            if (g)
                levels = levels | g_bit;
            if (r)
                levels = levels | r_bit;
        endfunction

        function logic [CNT_W-1:0] step_pattern(logic [3:0] g_bit, logic [3:0] r_bit,
                                                logic [2:0] pat);
            logic g;
            logic r;
            g = (levels & g_bit) != 4'd0;
            r = (levels & r_bit) != 4'd0;
            case (pat)
                PAT_OFF:
                begin
                    set_pair(g_bit, r_bit, 1'b0, 1'b0);
                    return ticks_or_one(steady_ticks);
                end
                PAT_GREEN:
                begin
                    set_pair(g_bit, r_bit, 1'b1, 1'b0);
                    return ticks_or_one(steady_ticks);
                end
                PAT_FLASH_G:
                begin
                    set_pair(g_bit, r_bit, !g, 1'b0);
                    return ticks_or_one(slow_ticks);
                end
                PAT_RED:
                begin
                    set_pair(g_bit, r_bit, 1'b0, 1'b1);
                    return ticks_or_one(steady_ticks);
                end
                PAT_FLASH_R:
                begin
                    set_pair(g_bit, r_bit, 1'b0, !r);
                    return ticks_or_one(slow_ticks);
                end
                PAT_ALT_SLOW, PAT_ALT_FAST:
                begin
                    if (g)
                        set_pair(g_bit, r_bit, 1'b0, 1'b1);
                    else
                        set_pair(g_bit, r_bit, 1'b1, 1'b0);
                    return (pat == PAT_ALT_SLOW) ? ticks_or_one(slow_ticks)
                                                 : ticks_or_one(fast_ticks);
                end
                default:
                begin
                    set_pair(g_bit, r_bit, 1'b1, 1'b1);
                    return ticks_or_one(steady_ticks);
                end
            endcase
        endfunction

        function logic [CNT_W-1:0] run_pair(logic [CNT_W-1:0] cnt, logic [3:0] g_bit,
                                            logic [3:0] r_bit, logic [2:0] pat);
            logic [CNT_W-1:0] c;
            c = cnt;
            if (c == '0)
                c = step_pattern(g_bit, r_bit, pat);
            return c - CNT_W'(1);
        endfunction

        function void apply_lamp_step();
            case (lamp_step)
                TST_SEP_0:
                begin
                    set_pair(LV_MG, LV_MR, 1'b1, 1'b0);
                    set_pair(LV_NG, LV_NR, 1'b0, 1'b0);
                    lamp_step = TST_SEP_1;
                end
                TST_SEP_1:
                begin
                    set_pair(LV_MG, LV_MR, 1'b0, 1'b1);
                    lamp_step = TST_SEP_2;
                end
                TST_SEP_2:
                begin
                    set_pair(LV_MG, LV_MR, 1'b1, 1'b0);
                    levels = levels | (combined ? LV_MG : LV_NG);
                    lamp_step = TST_SEP_3;
                end
                TST_SEP_3:
                begin
                    set_pair(LV_NG, LV_NR, 1'b0, 1'b1);
                    lamp_step = TST_SEP_4;
                end
                TST_SEP_4:
                begin
                    levels = levels & ~(combined ? LV_MR : LV_NR);
                    lamp_step = TEST_ENDED;
                end
                TST_COMB_0:
                begin
                    set_pair(LV_MG, LV_MR, 1'b1, 1'b0);
                    lamp_step = TST_COMB_1;
                end
                TST_COMB_1:
                begin
                    set_pair(LV_MG, LV_MR, 1'b0, 1'b1);
                    lamp_step = TST_COMB_2;
                end
                TST_COMB_2:
                begin
                    set_pair(LV_MG, LV_MR, 1'b0, 1'b0);
                    lamp_step = TEST_ENDED;
                end
                default: lamp_step = TEST_ENDED;
            endcase
            if (lamp_step == TEST_ENDED)
            begin
                mod_cnt = '0;
                net_cnt = '0;
            end
        endfunction

        function void module_event(logic [2:0] st);
            logic [2:0] p;
            case (st)
                MST_OPERATIONAL: p = PAT_GREEN;
                MST_STANDBY:     p = PAT_FLASH_G;
                MST_MINOR:       p = PAT_FLASH_R;
                MST_UNRECOV:     p = PAT_RED;
                MST_SELF_TEST:   p = PAT_ALT_SLOW;
                default:         return;
            endcase
            if (mod_pat != p)
            begin
                mod_pat = p;
                if (p == PAT_FLASH_R)
                    comb_pat = PAT_FLASH_R;
                mod_cnt = '0;
            end
        endfunction

        function void network_event(logic [2:0] st);
            logic [2:0] p;
            case (st)
                NST_OFFLINE:   p = PAT_OFF;
                NST_ONLINE:    p = PAT_FLASH_G;
                NST_CONNECTED: p = PAT_GREEN;
                NST_TIMEOUT:   p = PAT_FLASH_R;
                NST_LINK_FAIL: p = PAT_RED;
                NST_IDENTIFY:  p = PAT_ALT_FAST;
                default:       return;
            endcase
            if (net_pat != p)
            begin
                net_pat = p;
                comb_pat = p;
                net_cnt = '0;
            end
        endfunction

        function void note_item(mode_t m, logic [2:0] st);
            result_t leds;
            case (m)
                MODE_TICK:
                begin
                    if (lamp_step != TEST_ENDED)
                    begin
                        if (lamp_cnt <= CNT_W'(1))
                        begin
                            lamp_cnt = ticks_or_one(lamp_ticks);
                            apply_lamp_step();
                        end
                        else
                            lamp_cnt = lamp_cnt - CNT_W'(1);
                    end
                    else if (combined)
                        mod_cnt = run_pair(mod_cnt, LV_MG, LV_MR, comb_pat);
                    else
                    begin
                        mod_cnt = run_pair(mod_cnt, LV_MG, LV_MR, mod_pat);
                        net_cnt = run_pair(net_cnt, LV_NG, LV_NR, net_pat);
                    end
                end
                MODE_MODULE:  module_event(st);
                MODE_NETWORK: network_event(st);
                default:
                begin
                    if (lamp_step == TEST_ENDED)
                    begin
                        lamp_step = combined ? TST_COMB_0 : TST_SEP_0;
                        lamp_cnt = ticks_or_one(lamp_ticks);
                    end
                end
            endcase
            leds.module_green  = levels[0];
            leds.module_red    = levels[1];
            leds.network_green = combined ? levels[0] : levels[2];
            leds.network_red   = combined ? levels[1] : levels[3];
            leds.test_running  = lamp_step != TEST_ENDED;
            leds_due.push_back(leds);
        endfunction

        task check_leds(result_t got);
            result_t want;
            string   names[5] = '{"module_green", "module_red", "network_green",
                                  "network_red", "test_running"};
            if (leds_due.size() == 0)
                report("result arrived with no transaction outstanding");
            else
            begin
                want = leds_due.pop_front();
                for (int i = 0; i < 5; i++)
                    if (got[4-i] !== want[4-i])
                        report($sformatf("%s is %b, predicted %b", names[i], got[4-i],
                                         want[4-i]));
            end
        endtask
    endclass

    // All inputs of the block start at known values.
    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              in_valid = 1'b0;
    logic              in_stall;
    mode_t             mode = MODE_TICK;
    logic [2:0]        status = 3'd0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic              module_green;
    logic              module_red;
    logic              network_green;
    logic              network_red;
    logic              test_running;

    led_scoreboard sb;
    int            send_idle_pct = 0;
    int            recv_idle_pct = 0;
    int            hold_left = 0;
    int            cycles = 0;

    status_led_pattern_driver u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .mode          (mode),
        .status        (status),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .module_green  (module_green),
        .module_red    (module_red),
        .network_green (network_green),
        .network_red   (network_red),
        .test_running  (test_running)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // This process watches both channels. Everything is sampled at the rising edge,
    // before the nonblocking updates of that edge land, so a transaction counts
    // exactly when valid is high and stall is low at that edge.
    always @(posedge clk)
    begin : watch
        result_t got;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_item(mode, status);
            if (out_valid && !out_stall)
            begin
                got = {module_green, module_red, network_green, network_red, test_running};
                sb.check_leds(got);
            end
        end
    end

    // The receiver stalls at random. A long hold-off takes priority and is counted
    // down here, one cycle per edge, independently of the sender.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // If the run hangs anywhere, this watchdog ends it as a failure.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("status_led_pattern_driver_test: errors");
            $finish;
        end
    end

    // One register write: a setup phase, then the access phase, then an idle phase so
    // that back-to-back writes never assign psel twice in one time step.
    task apb_write(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.write_reg(idx, value);
        @(posedge clk);
    endtask

    task configure(logic comb, logic [15:0] slow, logic [15:0] fast, logic [15:0] steady,
                   logic [15:0] lamp);
        apb_write(REG_COMBINED, DATA_W'(comb));
        apb_write(REG_SLOW, DATA_W'(slow));
        apb_write(REG_FAST, DATA_W'(fast));
        apb_write(REG_STEADY, DATA_W'(steady));
        apb_write(REG_TEST_STEP, DATA_W'(lamp));
    endtask

    // Offers one transaction and returns at the edge that accepts it. Valid stays high
    // when the next transaction follows at once; it only drops for an idle gap.
    task send_item(mode_t m, logic [2:0] st);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        mode     <= m;
        status   <= st;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Called in the step of the last acceptance, so valid drops before the next edge.
    task end_burst();
        in_valid <= 1'b0;
    endtask

    // The first edge lets the watch process note the transaction accepted in the
    // calling step before the outstanding count is read.
    task wait_results();
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Ticks dominate so that patterns and the lamp test actually advance; events carry
    // any status code, the out-of-range ones included, and lamp test starts are rare
    // enough that normal flashing gets time in between.
    task send_random();
        int         pick;
        logic [2:0] st;
        pick = $urandom_range(0, 99);
        st   = 3'($urandom_range(0, 7));
        if (pick < 68)
            send_item(MODE_TICK, st);
        else if (pick < 82)
            send_item(MODE_MODULE, st);
        else if (pick < 96)
            send_item(MODE_NETWORK, st);
        else
            send_item(MODE_TEST, st);
    endtask

    // Register settings per phase. They switch the combined display on and off, use
    // zero intervals (which act as one tick), one tick and the largest interval.
    task phase_config(int ph);
        case (ph)
            0:       configure(1'b0, 16'd3, 16'd1, 16'd5, 16'd2);
            1:       configure(1'b1, 16'd1, 16'd2, 16'd0, 16'd1);
            2:       configure(1'b0, 16'd0, 16'd4, 16'd1, 16'd3);
            3:       configure(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd2);
            4:       configure(1'b0, 16'd2, 16'd0, 16'd3, 16'd1);
            default: configure(1'b1, 16'd5, 16'd3, 16'd2, 16'hFFFF);
        endcase
    endtask

    initial
    begin
        sb = new();
        send_idle_pct = 28;
        recv_idle_pct = 86;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part with the reset settings: a first tick refreshes both steady
        // green channels, then every module and network status code, valid or not.
        send_item(MODE_TICK, 3'd0);
        for (int st = 0; st < 8; st++)
            send_item(MODE_MODULE, 3'(st));
        for (int st = 0; st < 8; st++)
            send_item(MODE_NETWORK, 3'(st));
        end_burst();
        wait_results();
        repeat (DRAIN_MARGIN) @(posedge clk);

        // A zero slow interval and a one-tick lamp test: the second start request is
        // ignored while the test runs, five ticks walk the separate sequence, and the
        // ticks after it show normal patterns resuming from cleared countdowns.
        configure(1'b0, 16'd0, 16'd1, 16'd2, 16'd1);
        send_item(MODE_TEST, 3'd0);
        send_item(MODE_TEST, 3'd7);
        for (int n = 0; n < 7; n++)
            send_item(MODE_TICK, 3'(n));
        end_burst();
        wait_results();
        repeat (DRAIN_MARGIN) @(posedge clk);

        // Random part. The first two phases idle the receiver heavily, the next two
        // the sender, and the last two run at full rate. A lamp test may still be
        // running across a phase boundary, so settings also change under a test.
        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            if (ph < 2)
            begin
                send_idle_pct = 28;
                recv_idle_pct = 86;
            end
            else if (ph < 4)
            begin
                send_idle_pct = 86;
                recv_idle_pct = 28;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            phase_config(ph);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // With the receiver held off for a long stretch, the sender keeps
                // offering transactions until the pipeline fills and stalls its input.
                if (ph == 4 && n == 40)
                    hold_left = 400;
                // Here the sender goes quiet until every outstanding result is back.
                if (ph == 1 && n == 75)
                begin
                    end_burst();
                    wait_results();
                end
                send_random();
            end
            end_burst();
            wait_results();
            repeat (DRAIN_MARGIN) @(posedge clk);
        end

        if (sb.pending() != 0)
            sb.report("transactions left without a result");
        if (sb.errors == 0)
            $display("status_led_pattern_driver_test: clean");
        else
            $display("status_led_pattern_driver_test: errors");
        $finish;
    end

endmodule

/* status_led_pattern_driver.f */
hw/rtl/sldrv_pkg.sv
hw/rtl/sldrv_cfg.sv
hw/rtl/sldrv_engine.sv
hw/rtl/status_led_pattern_driver.sv
dv/status_led_pattern_driver_test.sv
